@@ design/keyed_top_n_leaderboard_macros.svh @@
// Assertion macros shared by the leaderboard checkers.
// Needs a clk and an active-low rst_n in the scope where the macros are used.
`ifndef KEYED_TOP_N_LEADERBOARD_MACROS_SVH
`define KEYED_TOP_N_LEADERBOARD_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define KTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define KTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ktl_pkg.sv @@
// Shared types and constants for the keyed top-N leaderboard.
// No dependencies; imported by every module of the block.
`default_nettype none

package ktl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Operation codes
  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] key_bytes;
    logic [31:0] score_bits;
    logic [31:0] world_ident;
    logic [31:0] world_sequence;
    logic [31:0] build_ident;
    logic [63:0] tick_stamp;
    logic [63:0] killer_bytes;
    logic [3:0]  read_index;
  } in_req_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  slot;
    logic [4:0]  entry_count;
    logic [63:0] out_key;
    logic [31:0] out_score;
    logic [31:0] out_world;
    logic [31:0] out_sequence;
    logic [31:0] out_build;
    logic [63:0] out_tick;
    logic [63:0] out_killer;
  } out_rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] score;
    logic [31:0] world;
    logic [31:0] seq;
    logic [31:0] build;
    logic [63:0] tick;
    logic [63:0] killer;
  } rec_t;

  typedef enum logic [1:0] {
    RSP_REJECT,
    RSP_SUBMIT,
    RSP_READ
  } rsp_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      latch_req;
    logic      clr_idx;
    logic      inc_idx;
    logic      do_remove;
    logic      do_insert;
    logic      load_out;
    rsp_kind_t rsp_kind;
  } ktl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic score_bad;
    logic key_empty;
    logic scan_end;
    logic key_hit;
    logic seq_reject;
    logic score_above;
    logic no_room;
    logic out_free;
  } ktl_sts_t;

endpackage

`default_nettype wire

@@ design/keyed_top_n_leaderboard.sv @@
// Keyed top-N leaderboard. One request at a time. A read goes from the check state straight
// to the result load; a submit is paced by the key scan and the insertion scan, each one record
// a cycle through the single table port.
// The next request is taken the cycle after the result is loaded; the result register holds
// it until out_ready. Synchronous active-low reset empties the table (count to zero).
`default_nettype none

module keyed_top_n_leaderboard import ktl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  ktl_cmd_t cmd;
  ktl_sts_t sts;

  ktl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ktl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/ktl_dpath.sv @@
// Datapath: request register, record table, scan index, count and result register.
// Depends on ktl_pkg; driven by ktl_ctrl through ktl_cmd_t.
`default_nettype none

module ktl_dpath import ktl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  ktl_cmd_t cmd,
  output ktl_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  in_req_t           req_r;
  rec_t              table_r [TABLE_DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  idx_nxt;
  logic [IDX_W-1:0]  slot_r;
  out_rsp_t          out_r;
  out_rsp_t          out_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  logic [63:0]       key_cut;
  logic [31:0]       score_n;
  logic              is_read;
  logic [IDX_W-1:0]  rd_addr;
  rec_t              rec_sel;
  rec_t              new_rec;
  logic              rd_ok;
  rec_t              up_rec [TABLE_DEPTH];
  rec_t              dn_rec [TABLE_DEPTH];

  // Drop the first zero byte of the key and everything above it
  function automatic logic [63:0] cut_key(input logic [63:0] k);
    logic [63:0] res;
    logic        live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (k[8*b +: 8] == 8'h00) live = 1'b0;
      if (live) res[8*b +: 8] = k[8*b +: 8];
    end
    return res;
  endfunction

  // Hold the request for the whole item
  always_ff @(posedge clk) begin
    if (cmd.latch_req) req_r <= in_data;
  end

  assign key_cut = cut_key(req_r.key_bytes);
  // Negative zero folds to positive zero
  assign score_n = req_r.score_bits[31] ? 32'h0 : req_r.score_bits;
  assign is_read = (req_r.operation == OP_READ);

  // One table read port, shared by the scan and the read request
  assign rd_addr = is_read ? IDX_W'(req_r.read_index) : idx_r[IDX_W-1:0];
  assign rec_sel = table_r[rd_addr];
  assign rd_ok   = (int'(req_r.read_index) < int'(count_r));

  assign new_rec.key    = key_cut;
  assign new_rec.score  = score_n;
  assign new_rec.world  = req_r.world_ident;
  assign new_rec.seq    = req_r.world_sequence;
  assign new_rec.build  = req_r.build_ident;
  assign new_rec.tick   = req_r.tick_stamp;
  assign new_rec.killer = req_r.killer_bytes;

  // Status toward the controller
  always_comb begin
    sts.is_read     = is_read;
    sts.score_bad   = (req_r.score_bits[30:23] == 8'hFF) ||
                      (req_r.score_bits[31] && (req_r.score_bits[30:0] != 31'h0));
    sts.key_empty   = (key_cut == 64'h0);
    sts.scan_end    = (idx_r >= count_r);
    sts.key_hit     = (rec_sel.key == key_cut);
    sts.seq_reject  = (req_r.world_sequence < rec_sel.seq) ||
                      ((req_r.world_sequence == rec_sel.seq) && (score_n <= rec_sel.score));
    sts.score_above = (score_n > rec_sel.score);
    sts.no_room     = (idx_r >= count_r) && (count_r == CNT_W'(TABLE_DEPTH));
    sts.out_free    = !out_valid_r || out_ready;
  end

  // Neighbor taps for the shift on insert and remove
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_tap
    if (j == 0) begin : g_first
      assign up_rec[j] = new_rec;
    end else begin : g_up
      assign up_rec[j] = table_r[j-1];
    end
    if (j == TABLE_DEPTH - 1) begin : g_last
      assign dn_rec[j] = table_r[j];
    end else begin : g_dn
      assign dn_rec[j] = table_r[j+1];
    end
  end

  // Insert at the scan index with the tail shifted down, or close the gap on remove
  always_ff @(posedge clk) begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (cmd.do_insert) begin
        if (CNT_W'(j) == idx_r) begin
          table_r[j] <= new_rec;
        end else if ((CNT_W'(j) > idx_r) && (CNT_W'(j) <= count_r)) begin
          table_r[j] <= up_rec[j];
        end
      end else if (cmd.do_remove) begin
        if ((CNT_W'(j) >= idx_r) && (CNT_W'(j + 1) < count_r)) begin
          table_r[j] <= dn_rec[j];
        end
      end
    end
  end

  // Record position of a placed submit
  always_ff @(posedge clk) begin
    if (cmd.do_insert) slot_r <= idx_r[IDX_W-1:0];
  end

  // Advance count and scan index
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.do_insert && (count_r < CNT_W'(TABLE_DEPTH))) begin
      count_nxt = count_r + CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.inc_idx) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Build the result
  always_comb begin
    out_nxt             = '0;
    out_nxt.entry_count = 5'(count_r);
    case (cmd.rsp_kind)
      RSP_SUBMIT: begin
        out_nxt.accepted = 1'b1;
        out_nxt.slot     = 4'(slot_r);
      end
      RSP_READ: begin
        out_nxt.slot = req_r.read_index;
        if (rd_ok) begin
          out_nxt.accepted     = 1'b1;
          out_nxt.out_key      = rec_sel.key;
          out_nxt.out_score    = rec_sel.score;
          out_nxt.out_world    = rec_sel.world;
          out_nxt.out_sequence = rec_sel.seq;
          out_nxt.out_build    = rec_sel.build;
          out_nxt.out_tick     = rec_sel.tick;
          out_nxt.out_killer   = rec_sel.killer;
        end
      end
      default: begin
        out_nxt.accepted = 1'b0;
      end
    endcase
  end

  // Result register: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ design/ktl_ctrl.sv @@
// Controller: sequences validity check, key scan, removal, insertion scan and result load.
// Depends on ktl_pkg; commands ktl_dpath through ktl_cmd_t.
`default_nettype none

module ktl_ctrl import ktl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ktl_sts_t sts,
  output ktl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_KEY_SCAN,
    S_INS_SCAN,
    S_LOAD
  } state_t;

  state_t    state_r;
  state_t    state_nxt;
  rsp_kind_t rsp_r;
  rsp_kind_t rsp_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    rsp_nxt       = rsp_r;
    cmd           = '0;
    cmd.rsp_kind  = rsp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      // Route the request: read, bad score, or scan
      S_CHECK: begin
        cmd.clr_idx = 1'b1;
        if (sts.is_read) begin
          rsp_nxt   = RSP_READ;
          state_nxt = S_LOAD;
        end else if (sts.score_bad) begin
          rsp_nxt   = RSP_REJECT;
          state_nxt = S_LOAD;
        end else if (sts.key_empty) begin
          state_nxt = S_INS_SCAN;
        end else begin
          state_nxt = S_KEY_SCAN;
        end
      end
      // Look for a record with the same key
      S_KEY_SCAN: begin
        if (sts.scan_end) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_INS_SCAN;
        end else if (sts.key_hit) begin
          if (sts.seq_reject) begin
            rsp_nxt   = RSP_REJECT;
            state_nxt = S_LOAD;
          end else begin
            cmd.do_remove = 1'b1;
            cmd.clr_idx   = 1'b1;
            state_nxt     = S_INS_SCAN;
          end
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      // Find the first strictly lower score
      S_INS_SCAN: begin
        if (sts.scan_end) begin
          if (sts.no_room) begin
            rsp_nxt = RSP_REJECT;
          end else begin
            cmd.do_insert = 1'b1;
            rsp_nxt       = RSP_SUBMIT;
          end
          state_nxt = S_LOAD;
        end else if (sts.score_above) begin
          cmd.do_insert = 1'b1;
          rsp_nxt       = RSP_SUBMIT;
          state_nxt     = S_LOAD;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      // Wait for the result register to free up
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rsp_r   <= RSP_REJECT;
    end else begin
      state_r <= state_nxt;
      rsp_r   <= rsp_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/ktl_checker.sv @@
// Port-level checks for the leaderboard, bound to the top level.
// Depends on ktl_pkg and keyed_top_n_leaderboard_macros.svh.
`default_nettype none

`include "keyed_top_n_leaderboard_macros.svh"

module ktl_checker import ktl_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_rsp_t out_data
);

  // One request in flight: no back-to-back acceptance
  `KTL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")

  // Count never exceeds the table depth
  `KTL_ASSERT_NOW(a_count_bound, out_valid, int'(out_data.entry_count) <= TABLE_DEPTH, "count over depth")

  // A stored or read record implies a non-empty table
  `KTL_ASSERT_NOW(a_accept_count, out_valid && out_data.accepted, out_data.entry_count != 5'd0, "accepted with empty table")

  // A stalled result holds
  `KTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind keyed_top_n_leaderboard ktl_checker u_chk (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for keyed_top_n_leaderboard: directed corner cases, then random submits and reads.
// A class mirrors the score table and checks each response in order. Needs ktl_pkg.
module testbench;
  import ktl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_REQUESTS = 1550;
  localparam int unsigned HOLD_START = 4000;
  localparam int unsigned HOLD_SPAN = 600;
  localparam int unsigned DRAIN_CYCLES = 60;

  // Mirror of the score table; predicts and checks every response
  class board_mirror;
    rec_t board[TABLE_DEPTH];
    int filled;
    out_rsp_t pending_results[$];
    int unsigned errors;

    function new();
      foreach (board[i]) board[i] = '0;
      filled = 0;
      errors = 0;
    endfunction

    // Update the table for one accepted request and queue its response
    function void apply_request(in_req_t r);
      out_rsp_t e;
      rec_t nr;
      logic [31:0] sc;
      logic [63:0] key;
      bit ok;
      bit stop;
      int ins;
      int last;
      e = '0;
      if (r.operation == OP_READ) begin
        e.slot = r.read_index;
        if (int'(r.read_index) < filled) begin
          e.accepted = 1'b1;
          e.out_key = board[r.read_index].key;
          e.out_score = board[r.read_index].score;
          e.out_world = board[r.read_index].world;
          e.out_sequence = board[r.read_index].seq;
          e.out_build = board[r.read_index].build;
          e.out_tick = board[r.read_index].tick;
          e.out_killer = board[r.read_index].killer;
        end
      end else begin
        ok = 1'b1;
        sc = r.score_bits;
        // cut the key at its first zero byte
        key = '0;
        stop = 1'b0;
        for (int b = 0; b < 8; b++) begin
          if (r.key_bytes[8*b +: 8] == 8'h00) stop = 1'b1;
          if (!stop) key[8*b +: 8] = r.key_bytes[8*b +: 8];
        end
        // reject infinities, NaNs and negatives; fold negative zero
        if (sc[30:23] == 8'hFF) begin
          ok = 1'b0;
        end else if (sc[31]) begin
          if (sc[30:0] != '0) ok = 1'b0;
          else sc = '0;
        end
        // resolve an existing record with the same key
        if (ok && key != '0) begin
          for (int i = 0; i < filled; i++) begin
            if (board[i].key == key) begin
              if (r.world_sequence < board[i].seq) begin
                ok = 1'b0;
              end else if (r.world_sequence == board[i].seq && sc <= board[i].score) begin
                ok = 1'b0;
              end else begin
                for (int j = i; j + 1 < filled; j++) board[j] = board[j+1];
                filled--;
                board[filled] = '0;
              end
              break;
            end
          end
        end
        // insert ahead of the first strictly lower score, dropping the tail
        if (ok) begin
          ins = filled;
          for (int i = 0; i < filled; i++) begin
            if (sc > board[i].score) begin
              ins = i;
              break;
            end
          end
          if (ins < TABLE_DEPTH) begin
            last = (filled < TABLE_DEPTH) ? filled : TABLE_DEPTH - 1;
            for (int i = last; i > ins; i--) board[i] = board[i-1];
            nr.key = key;
            nr.score = sc;
            nr.world = r.world_ident;
            nr.seq = r.world_sequence;
            nr.build = r.build_ident;
            nr.tick = r.tick_stamp;
            nr.killer = r.killer_bytes;
            board[ins] = nr;
            if (filled < TABLE_DEPTH) filled++;
            e.accepted = 1'b1;
            e.slot = ins[3:0];
          end
        end
      end
      e.entry_count = filled[4:0];
      pending_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] have);
      if (want !== have) begin
        $error("%s: expected %0h, got %0h", name, want, have);
        errors++;
      end
    endfunction

    // Compare one response against the oldest prediction
    function void check_response(out_rsp_t got);
      out_rsp_t e;
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding: %0h", got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("accepted", 64'(e.accepted), 64'(got.accepted));
      compare_field("slot", 64'(e.slot), 64'(got.slot));
      compare_field("entry_count", 64'(e.entry_count), 64'(got.entry_count));
      compare_field("out_key", e.out_key, got.out_key);
      compare_field("out_score", 64'(e.out_score), 64'(got.out_score));
      compare_field("out_world", 64'(e.out_world), 64'(got.out_world));
      compare_field("out_sequence", 64'(e.out_sequence), 64'(got.out_sequence));
      compare_field("out_build", 64'(e.out_build), 64'(got.out_build));
      compare_field("out_tick", e.out_tick, got.out_tick);
      compare_field("out_killer", e.out_killer, got.out_killer);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_data;

  board_mirror mirror = new();
  logic [63:0] key_pool[20];
  int unsigned cycle_count = 0;

  keyed_top_n_leaderboard uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Track accepted requests and check delivered responses
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) mirror.apply_request(in_data);
    if (rst_n && out_valid && out_ready) mirror.check_response(out_data);
  end

  function automatic in_req_t make_request(logic op, logic [63:0] key, logic [31:0] score,
                                           logic [31:0] seq, logic [3:0] idx);
    in_req_t r;
    r.operation = op;
    r.key_bytes = key;
    r.score_bits = score;
    r.world_ident = $urandom;
    r.world_sequence = seq;
    r.build_ident = $urandom;
    r.tick_stamp = {$urandom, $urandom};
    r.killer_bytes = {$urandom, $urandom};
    r.read_index = idx;
    return r;
  endfunction

  // Random request: mostly pool keys with small sequences so replacements happen often
  function automatic in_req_t build_request();
    logic [63:0] key;
    logic [31:0] score;
    logic [31:0] seq;
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      return make_request(OP_READ, {$urandom, $urandom}, $urandom, $urandom,
                          4'($urandom_range(0, 15)));
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      key = key_pool[$urandom_range(0, 19)];
    end else if (pick < 88) begin
      key = {$urandom, $urandom};
    end else if (pick < 93) begin
      key = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00;
    end else begin
      key = key_pool[$urandom_range(0, 19)] ^ ({$urandom, $urandom} << 32);
      cut = $urandom_range(1, 7);
      key[8*cut +: 8] = 8'h00;
    end
    seq = ($urandom_range(0, 99) < 88) ? 32'($urandom_range(0, 3)) : 32'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 2))
        0: score = 32'h3F80_0000;
        1: score = 32'h4000_0000;
        default: score = 32'h4040_0000;
      endcase
    end else if (pick < 85) begin
      score = {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
    end else begin
      case ($urandom_range(0, 3))
        0: score = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom)};
        1: score = 32'h8000_0000;
        2: score = {1'b1, 31'($urandom)};
        default: score = 32'h7F80_0000;
      endcase
    end
    return make_request(OP_SUBMIT, key, score, seq, 4'($urandom_range(0, 15)));
  endfunction

  // Offer one request and hold it until the handshake
  task automatic send_request(input in_req_t r);
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_input(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Result side: stall on mixed patterns, with one long hold-off
  initial begin
    int unsigned ticks;
    int mode;
    int span;
    bit held;
    logic rdy;
    ticks = 0;
    held = 1'b0;
    forever begin
      if (!held && ticks >= HOLD_START) begin
        out_ready <= 1'b0;
        repeat (HOLD_SPAN) @(posedge clk);
        ticks += HOLD_SPAN;
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 80);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = (k % 3 != 0);
        endcase
        out_ready <= rdy;
        @(posedge clk);
        ticks++;
      end
    end
  end

  // Request side: reset, directed cases, random bursts, drain
  initial begin
    in_req_t req;
    int unsigned burst_left;
    for (int k = 0; k < 20; k++)
      for (int b = 0; b < 8; b++) key_pool[k][8*b +: 8] = 8'($urandom_range(1, 255));
    // two pool keys that cut to the same name
    key_pool[17][63:32] = 32'h0;
    key_pool[18] = {key_pool[5][63:40], 8'h00, key_pool[17][31:0]};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reads on an empty table
    send_request(make_request(OP_READ, '1, '1, '1, 4'd0));
    send_request(make_request(OP_READ, '0, '0, '0, 4'd15));
    // full key, largest finite score, payload all ones
    req = make_request(OP_SUBMIT, '1, 32'h7F7F_FFFF, 32'd5, 4'd15);
    req.world_ident = '1;
    req.build_ident = '1;
    req.tick_stamp = '1;
    req.killer_bytes = '1;
    send_request(req);
    // infinity, NaN and a negative score are refused
    send_request(make_request(OP_SUBMIT, 64'h0000_0000_0000_4241, 32'h7F80_0000, 32'd0, 4'd0));
    send_request(make_request(OP_SUBMIT, 64'h0000_0000_0000_4241, 32'hFFFF_FFFF, 32'd0, 4'd0));
    send_request(make_request(OP_SUBMIT, 64'h0000_0000_0000_4241, 32'hBF80_0000, 32'd0, 4'd0));
    // negative zero stored as zero, payload all zeros
    req = make_request(OP_SUBMIT, 64'h0000_0000_0000_4241, 32'h8000_0000, 32'd0, 4'd0);
    req.world_ident = '0;
    req.build_ident = '0;
    req.tick_stamp = '0;
    req.killer_bytes = '0;
    send_request(req);
    // empty keys never match each other
    send_request(make_request(OP_SUBMIT, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 32'd9, 4'd0));
    send_request(make_request(OP_SUBMIT, 64'h1234_5678_9ABC_DE00, 32'h0, 32'd1, 4'd0));
    // same cut key: older, equal not higher, equal higher, newer lower
    send_request(make_request(OP_SUBMIT, 64'hFFFF_FF00_0000_4443, 32'h3F80_0000, 32'd7, 4'd0));
    send_request(make_request(OP_SUBMIT, 64'h1234_5600_0000_4443, 32'h4000_0000, 32'd6, 4'd0));
    send_request(make_request(OP_SUBMIT, 64'h0000_0000_0000_4443, 32'h3F80_0000, 32'd7, 4'd0));
    send_request(make_request(OP_SUBMIT, 64'hAB00_0000_0000_4443, 32'h4000_0000, 32'd7, 4'd0));
    send_request(make_request(OP_SUBMIT, 64'h0000_0000_0000_4443, 32'h3F00_0000, 32'd8, 4'd0));
    // smallest denormal with the largest sequence
    send_request(make_request(OP_SUBMIT, 64'h0102_0304_0506_0708, 32'h0000_0001, '1, 4'd0));
    // read back the table, including past the end
    for (int i = 0; i < 8; i++)
      send_request(make_request(OP_READ, {$urandom, $urandom}, $urandom, $urandom, 4'(i)));

    // random requests in bursts
    burst_left = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_request(build_request());
    end
    in_valid <= 1'b0;

    // wait for every response, then let the block settle
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
